// ===== hw/rtl/dense_dijkstra_shortest_paths_defines.svh =====
// Assertion macros for the shortest path block.
`ifndef DENSE_DIJKSTRA_SHORTEST_PATHS_DEFINES_SVH
`define DENSE_DIJKSTRA_SHORTEST_PATHS_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication.
`define DDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define DDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`else

`define DDS_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg)
`define DDS_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/dds_pkg.sv =====
package dds_pkg;

  // Default sizes.
  localparam int NODES_DEF       = 16;
  localparam int WEIGHT_BITS_DEF = 16;

  // Fixed field widths.
  localparam int NODE_W     = 6;
  localparam int WEIGHT_W   = 16;
  localparam int DIST_W     = 22;
  localparam int NCOUNT_W   = 7;
  localparam logic [DIST_W-1:0] DIST_MAX = 22'h3FFFFF;

  // Stream word widths.
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 40;
  localparam int OUT_USER_W = 2;

  // Configuration port.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 7;

  localparam logic [NCOUNT_W-1:0] NODE_COUNT_RST = 7'd16;
  localparam logic [NODE_W-1:0]   SOURCE_RST     = 6'd0;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NODE_COUNT  = 1'b0,
    CFG_SOURCE_NODE = 1'b1
  } cfg_reg_e;

endpackage

// ===== hw/rtl/dds_weight_store.sv =====
module dds_weight_store #(
  parameter int NODES       = dds_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = dds_pkg::WEIGHT_BITS_DEF,
  localparam int DEPTH      = NODES * NODES,
  localparam int AW         = $clog2(DEPTH)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   we_i,
  input  logic [AW-1:0]          waddr_i,
  input  logic [WEIGHT_BITS-1:0] wdata_i,
  input  logic [AW-1:0]          raddr_i,
  output logic [WEIGHT_BITS-1:0] rdata_o,
  output logic                   busy_o
);

  logic [WEIGHT_BITS-1:0] mem [DEPTH];
  logic [WEIGHT_BITS-1:0] rdata_q;
  logic                   clearing_q;
  logic [AW-1:0]          clr_addr_q;

  // Sweep zeros through every entry after reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (clearing_q) begin
      mem[clr_addr_q] <= '0;
    end else if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clearing_q;

endmodule

// ===== hw/rtl/dense_dijkstra_shortest_paths.sv =====
// Load words: one per cycle while s_axis_tready is high, no result. After reset a
// clearing pass zeroes every weight store entry while s_axis_tready stays low.
// Last word: R search rounds (n nodes in use, R <= n-1 rounds), fewer when the rounds
// stop early, then one result per node in use, each held until the sink is ready.
// No new word is taken until the final result leaves. Reset is asynchronous, active
// low; it clears control state only.
`include "dense_dijkstra_shortest_paths_defines.svh"

module dense_dijkstra_shortest_paths #(
  parameter int NODES       = dds_pkg::NODES_DEF,
  parameter int WEIGHT_BITS = dds_pkg::WEIGHT_BITS_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // Configuration write channel.
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [dds_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [dds_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  // Load stream.
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // tdata: row [5:0], col [11:6], weight [27:12], zero [31:28]
  input  logic [dds_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  input  logic                            s_axis_tlast,
  // Result stream.
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // tdata: node [5:0], distance [27:6], predecessor [33:28], zero [39:34]
  output logic [dds_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: reachable [0], has_predecessor [1]
  output logic [dds_pkg::OUT_USER_W-1:0]  m_axis_tuser,
  output logic                            m_axis_tlast
);

  localparam int IDX_W  = $clog2(NODES);
  localparam int AW     = $clog2(NODES * NODES);
  localparam int DIST_W = dds_pkg::DIST_W;
  localparam int NODE_W = dds_pkg::NODE_W;
  localparam int NC_W   = dds_pkg::NCOUNT_W;
  localparam int SUM_W  = ((WEIGHT_BITS > DIST_W) ? WEIGHT_BITS : DIST_W) + 1;

  // Sequencer states, one-hot.
  typedef enum logic [9:0] {
    ST_IDLE       = 10'b00_0000_0001,
    ST_INIT       = 10'b00_0000_0010,
    ST_SEL        = 10'b00_0000_0100,
    ST_SEL_TAIL   = 10'b00_0000_1000,
    ST_PICK       = 10'b00_0001_0000,
    ST_RELAX      = 10'b00_0010_0000,
    ST_RELAX_TAIL = 10'b00_0100_0000,
    ST_EMIT_RD    = 10'b00_1000_0000,
    ST_EMIT_LD    = 10'b01_0000_0000,
    ST_EMIT_HOLD  = 10'b10_0000_0000
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers. Writes must be issued only while idle; the block does not enforce it.
  // ---------------------------------------------------------------------------
  logic [NC_W-1:0]   node_count_q;
  logic [NODE_W-1:0] source_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= dds_pkg::NODE_COUNT_RST;
      source_q     <= dds_pkg::SOURCE_RST;
    end else if (cfg_valid_i) begin
      unique case (dds_pkg::cfg_reg_e'(cfg_index_i))
        dds_pkg::CFG_NODE_COUNT:  node_count_q <= cfg_data_i[NC_W-1:0];
        dds_pkg::CFG_SOURCE_NODE: source_q     <= cfg_data_i[NODE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the node count into 1..NODES; keep n-1 as the last index.
  logic [NC_W-1:0]  n_use;
  logic [IDX_W-1:0] last_i_cfg;

  always_comb begin
    if (node_count_q == '0) begin
      n_use = NC_W'(1);
    end else if (node_count_q > NC_W'(NODES)) begin
      n_use = NC_W'(NODES);
    end else begin
      n_use = node_count_q;
    end
    last_i_cfg = IDX_W'(n_use - NC_W'(1));
  end

  // ---------------------------------------------------------------------------
  // Load word unpacking and weight store.
  // ---------------------------------------------------------------------------
  logic [NODE_W-1:0]       in_row;
  logic [NODE_W-1:0]       in_col;
  logic [dds_pkg::WEIGHT_W-1:0] in_weight;
  logic                    in_acc;
  logic                    in_ok;
  logic [AW-1:0]           ws_waddr;
  logic [AW-1:0]           ws_raddr;
  logic [WEIGHT_BITS-1:0]  ws_rdata;
  logic                    ws_busy;

  state_e state_q, state_d;

  assign in_row    = s_axis_tdata[5:0];
  assign in_col    = s_axis_tdata[11:6];
  assign in_weight = s_axis_tdata[27:12];

  assign s_axis_tready = (state_q == ST_IDLE) && !ws_busy;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  // Drop entries outside the matrix; the last flag still acts.
  assign in_ok = (NC_W'(in_row) < NC_W'(NODES)) && (NC_W'(in_col) < NC_W'(NODES));
  assign ws_waddr = AW'(AW'(in_row[IDX_W-1:0]) * AW'(NODES)) + AW'(in_col[IDX_W-1:0]);

  logic [AW-1:0]    row_base_q, row_base_d;
  logic [IDX_W-1:0] i_q, i_d;

  assign ws_raddr = row_base_q + AW'(i_q);

  dds_weight_store #(
    .NODES       (NODES),
    .WEIGHT_BITS (WEIGHT_BITS)
  ) u_weight_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (in_acc && in_ok),
    .waddr_i (ws_waddr),
    .wdata_i (WEIGHT_BITS'(in_weight)),
    .raddr_i (ws_raddr),
    .rdata_o (ws_rdata),
    .busy_o  (ws_busy)
  );

  // ---------------------------------------------------------------------------
  // Distance and predecessor tables: one read port at i_q, registered data.
  // ---------------------------------------------------------------------------
  logic [DIST_W-1:0] dist_mem [NODES];
  logic [IDX_W-1:0]  pred_mem [NODES];
  logic [DIST_W-1:0] dist_rd_q;
  logic [IDX_W-1:0]  pred_rd_q;
  logic              tw_en;
  logic [IDX_W-1:0]  tw_addr;
  logic [DIST_W-1:0] tw_dist;

  logic [IDX_W-1:0]  u_q, u_d;

  always_ff @(posedge clk_i) begin
    if (tw_en) begin
      dist_mem[tw_addr] <= tw_dist;
      pred_mem[tw_addr] <= u_q;
    end
    dist_rd_q <= dist_mem[i_q];
    pred_rd_q <= pred_mem[i_q];
  end

  // ---------------------------------------------------------------------------
  // Sequencer and shared compare unit.
  // ---------------------------------------------------------------------------
  logic [IDX_W-1:0]  round_q, round_d;
  logic [IDX_W-1:0]  last_i_q, last_i_d;
  logic [DIST_W-1:0] best_q, best_d;
  logic              found_q, found_d;
  logic [NODES-1:0]  visited_q, visited_d;
  logic [NODES-1:0]  reached_q, reached_d;
  logic              p_valid_q, p_valid_d;
  logic [IDX_W-1:0]  p_idx_q, p_idx_d;

  logic [NODE_W-1:0] out_node_q, out_node_d;
  logic [DIST_W-1:0] out_dist_q, out_dist_d;
  logic [NODE_W-1:0] out_pred_q, out_pred_d;
  logic              out_reach_q, out_reach_d;
  logic              out_haspred_q, out_haspred_d;
  logic              out_last_q, out_last_d;
  logic              out_valid_q, out_valid_d;

  logic [IDX_W-1:0]  src_idx;
  logic              src_bad;
  logic              relax_phase;
  logic              sel_phase;
  logic [SUM_W-1:0]  sum;
  logic [DIST_W-1:0] sum_sat;
  logic [DIST_W-1:0] cmp_a;
  logic [DIST_W-1:0] cmp_b;
  logic              cmp_lt;
  logic              sel_take;
  logic              rlx_upd;
  logic              emit_reach;
  logic              emit_haspred;

  assign src_idx = source_q[IDX_W-1:0];
  assign src_bad = NC_W'(source_q) > NC_W'(last_i_q);

  assign sel_phase   = (state_q == ST_SEL) || (state_q == ST_SEL_TAIL);
  assign relax_phase = (state_q == ST_RELAX) || (state_q == ST_RELAX_TAIL);

  // Saturating path length through the picked node.
  assign sum     = SUM_W'(best_q) + SUM_W'(ws_rdata);
  assign sum_sat = (sum > SUM_W'(dds_pkg::DIST_MAX)) ? dds_pkg::DIST_MAX
                                                      : sum[DIST_W-1:0];

  // One less-than serves both scans: candidate vs best while selecting,
  // new path vs stored distance while relaxing.
  assign cmp_a  = relax_phase ? sum_sat   : dist_rd_q;
  assign cmp_b  = relax_phase ? dist_rd_q : best_q;
  assign cmp_lt = cmp_a < cmp_b;

  // Lowest index wins ties: strict compare in index order.
  assign sel_take = p_valid_q && sel_phase && !visited_q[p_idx_q] && reached_q[p_idx_q]
                    && (!found_q || cmp_lt);
  assign rlx_upd  = p_valid_q && relax_phase && !visited_q[p_idx_q]
                    && (ws_rdata != '0) && (!reached_q[p_idx_q] || cmp_lt);

  assign emit_reach   = reached_q[i_q];
  assign emit_haspred = emit_reach && (i_q != src_idx);

  always_comb begin
    state_d       = state_q;
    i_d           = i_q;
    round_d       = round_q;
    last_i_d      = last_i_q;
    u_d           = u_q;
    best_d        = best_q;
    found_d       = found_q;
    row_base_d    = row_base_q;
    visited_d     = visited_q;
    reached_d     = reached_q;
    p_valid_d     = 1'b0;
    p_idx_d       = i_q;
    out_node_d    = out_node_q;
    out_dist_d    = out_dist_q;
    out_pred_d    = out_pred_q;
    out_reach_d   = out_reach_q;
    out_haspred_d = out_haspred_q;
    out_last_d    = out_last_q;
    out_valid_d   = out_valid_q;
    tw_en         = 1'b0;
    tw_addr       = p_idx_q;
    tw_dist       = sum_sat;

    // Sample returning from the previous scan cycle.
    if (sel_take) begin
      found_d = 1'b1;
      best_d  = dist_rd_q;
      u_d     = p_idx_q;
    end
    if (rlx_upd) begin
      tw_en              = 1'b1;
      reached_d[p_idx_q] = 1'b1;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && s_axis_tlast) begin
          visited_d = '0;
          reached_d = '0;
          last_i_d  = last_i_cfg;
          state_d   = ST_INIT;
        end
      end
      ST_INIT: begin
        i_d     = '0;
        round_d = '0;
        found_d = 1'b0;
        if (src_bad) begin
          state_d = ST_EMIT_RD;
        end else begin
          reached_d[src_idx] = 1'b1;
          tw_en   = 1'b1;
          tw_addr = src_idx;
          tw_dist = '0;
          state_d = (last_i_q == '0) ? ST_EMIT_RD : ST_SEL;
        end
      end
      ST_SEL: begin
        p_valid_d = 1'b1;
        if (i_q == last_i_q) begin
          state_d = ST_SEL_TAIL;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_SEL_TAIL: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        i_d = '0;
        if (!found_q) begin
          state_d = ST_EMIT_RD;
        end else begin
          visited_d[u_q] = 1'b1;
          row_base_d     = AW'(AW'(u_q) * AW'(NODES));
          state_d        = ST_RELAX;
        end
      end
      ST_RELAX: begin
        p_valid_d = 1'b1;
        if (i_q == last_i_q) begin
          state_d = ST_RELAX_TAIL;
        end else begin
          i_d = i_q + IDX_W'(1);
        end
      end
      ST_RELAX_TAIL: begin
        i_d     = '0;
        found_d = 1'b0;
        if (round_q + IDX_W'(1) == last_i_q) begin
          state_d = ST_EMIT_RD;
        end else begin
          round_d = round_q + IDX_W'(1);
          state_d = ST_SEL;
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        out_node_d    = NODE_W'(i_q);
        out_dist_d    = emit_reach ? dist_rd_q : '0;
        out_pred_d    = emit_haspred ? NODE_W'(pred_rd_q) : '0;
        out_reach_d   = emit_reach;
        out_haspred_d = emit_haspred;
        out_last_d    = (i_q == last_i_q);
        out_valid_d   = 1'b1;
        state_d       = ST_EMIT_HOLD;
      end
      ST_EMIT_HOLD: begin
        if (m_axis_tready) begin
          out_valid_d = 1'b0;
          if (i_q == last_i_q) begin
            state_d = ST_IDLE;
          end else begin
            i_d     = i_q + IDX_W'(1);
            state_d = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      i_q         <= '0;
      round_q     <= '0;
      last_i_q    <= '0;
      found_q     <= 1'b0;
      visited_q   <= '0;
      reached_q   <= '0;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      round_q     <= round_d;
      last_i_q    <= last_i_d;
      found_q     <= found_d;
      visited_q   <= visited_d;
      reached_q   <= reached_d;
      p_valid_q   <= p_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    u_q           <= u_d;
    best_q        <= best_d;
    row_base_q    <= row_base_d;
    p_idx_q       <= p_idx_d;
    out_node_q    <= out_node_d;
    out_dist_q    <= out_dist_d;
    out_pred_q    <= out_pred_d;
    out_reach_q   <= out_reach_d;
    out_haspred_q <= out_haspred_d;
    out_last_q    <= out_last_d;
  end

  // Result word.
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_pred_q, out_dist_q, out_node_q};
  assign m_axis_tuser  = {out_haspred_q, out_reach_q};
  assign m_axis_tlast  = out_last_q;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  `DDS_ASSERT_IMP(a_out_only_in_hold, clk_i, rst_ni, out_valid_q, state_q == ST_EMIT_HOLD, "result shown outside hold state")
  `DDS_ASSERT_IMP(a_visited_reached, clk_i, rst_ni, 1'b1, (visited_q & ~reached_q) == '0, "visited node never reached")
  `DDS_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, m_axis_tvalid && m_axis_tready && m_axis_tlast, state_q == ST_IDLE, "no return to idle after final result")
  `DDS_ASSERT_IMP(a_busy_no_load, clk_i, rst_ni, ws_busy, !s_axis_tready, "load taken during clearing pass")

endmodule
